### src/linear_byte_buffer_with_search_assert.svh
// Assertion macros shared by the linear byte buffer RTL.
`ifndef LINEAR_BYTE_BUFFER_WITH_SEARCH_ASSERT_SVH
`define LINEAR_BYTE_BUFFER_WITH_SEARCH_ASSERT_SVH

`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define LBBS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("linear byte buffer assertion failed");
// Check that a condition implies a consequence in the same cycle.
`define LBBS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("linear byte buffer implication failed");
`else
`define LBBS_ASSERT(label, clk, rst_n, prop)
`define LBBS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif

`endif

### src/lbbs_pkg.sv
// Shared types and constants of the linear byte buffer.
package lbbs_pkg;

  localparam int unsigned DEPTH_DEF    = 256;
  localparam int unsigned MAX_READ_DEF = 64;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SIZE_W   = 9;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned OFFSET_W = 9;
  localparam int unsigned LEVEL_W  = 9;
  localparam int unsigned ACTION_W = 2;

  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned REG_IDX_W = APB_AW - 2;

  localparam logic [REG_IDX_W-1:0] REG_BUFFER_SIZE = '0;
  localparam logic [SIZE_W-1:0]    SIZE_RESET      = 9'd256;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE  = 2'd0,
    ACT_READ   = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEARCH
  } state_e;

  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic                accepted;
    logic [COUNT_W-1:0]  moved_count;
    logic                found;
    logic [OFFSET_W-1:0] next_offset;
    logic [LEVEL_W-1:0]  level;
    logic                is_empty;
    logic                is_full;
    logic                last;
  } result_t;

endpackage

### src/lbbs_store.sv
// Byte store: one write port, one read port with registered read data.
module lbbs_store #(
  parameter int unsigned  DEPTH = lbbs_pkg::DEPTH_DEF,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [lbbs_pkg::BYTE_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [lbbs_pkg::BYTE_W-1:0] rdata_o
);
  import lbbs_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/linear_byte_buffer_with_search.sv
// Linear byte buffer with search: top level with sequencer and APB register.
//
// A linear (non-wrapping) byte store with a write index and a read index.
// Each input word carries one action: write a byte, read up to read_count
// bytes (or only count them when discard is set), search the unread bytes
// for a byte starting at start_offset past the read index, or clear both
// indices. A write into an empty buffer rewinds both indices to zero first;
// a write is refused once the write index reaches buffer_size (saturated to
// DEPTH). Every result word carries level, is_empty and is_full as they
// stand after the action, and last marks the final result of an input.
// Timing: a write, a clear, a discard, a read that moves nothing and a
// search that starts past the written data finish in idle, so such words
// stream at one per cycle while the output is not stalled. A read of n
// bytes issues the first store read on acceptance and then one byte leaves
// per cycle while the output is not stalled, the single store read port
// fetching the next byte while the current one is delivered. A search does
// one store read per cycle while the output is not stalled. A new
// word is taken only in idle and only while the output register is empty or
// hands its result on in the same cycle, so a result held by an output stall
// holds off the next word. The store needs no clearing after reset.
`include "linear_byte_buffer_with_search_assert.svh"

module linear_byte_buffer_with_search #(
  parameter int unsigned DEPTH    = lbbs_pkg::DEPTH_DEF,
  parameter int unsigned MAX_READ = lbbs_pkg::MAX_READ_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lbbs_pkg::APB_AW-1:0]   paddr,
  input  logic [lbbs_pkg::APB_DW-1:0]   pwdata,
  output logic [lbbs_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lbbs_pkg::ACTION_W-1:0] action_i,
  input  logic [lbbs_pkg::BYTE_W-1:0]   data_byte_i,
  input  logic [lbbs_pkg::COUNT_W-1:0]  read_count_i,
  input  logic                          discard_i,
  input  logic [lbbs_pkg::OFFSET_W-1:0] start_offset_i,
  // result words
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lbbs_pkg::BYTE_W-1:0]   out_byte_o,
  output logic                          accepted_o,
  output logic [lbbs_pkg::COUNT_W-1:0]  moved_count_o,
  output logic                          found_o,
  output logic [lbbs_pkg::OFFSET_W-1:0] next_offset_o,
  output logic [lbbs_pkg::LEVEL_W-1:0]  level_o,
  output logic                          is_empty_o,
  output logic                          is_full_o,
  output logic                          last_o
);
  import lbbs_pkg::*;

  // Index width holds DEPTH itself; compare width covers both the index
  // and the 9-bit size register; position width adds the search offset.
  localparam int unsigned IDX_W = $clog2(DEPTH + 1);
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = (IDX_W > SIZE_W) ? IDX_W : SIZE_W;
  localparam int unsigned PW    = CW + 1;

  localparam logic [CW-1:0]      DEPTH_C    = CW'(DEPTH);
  localparam logic [COUNT_W-1:0] MAX_READ_C = COUNT_W'(MAX_READ);

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    wi_q, wi_d;
  logic [IDX_W-1:0]    ri_q, ri_d;
  logic [IDX_W-1:0]    addr_q, addr_d;   // next read address / scan address
  logic [COUNT_W-1:0]  n_q, n_d;         // bytes moved by the current read
  logic [COUNT_W-1:0]  k_q, k_d;         // bytes already delivered
  logic [BYTE_W-1:0]   byte_q, byte_d;   // byte sought by the search
  logic [SIZE_W-1:0]   size_q;
  result_t             res_q, res_d;
  logic                out_valid_q;
  logic                res_load;

  action_e             act;
  logic                in_acc;
  logic                out_free;

  logic [CW-1:0]       size_ext;
  logic [CW-1:0]       eff_c;
  logic [IDX_W-1:0]    wi_base, ri_base;
  logic                wr_ok;
  logic [IDX_W-1:0]    avail;
  logic [CW-1:0]       avail_c;
  logic [COUNT_W-1:0]  req_sat;
  logic [COUNT_W-1:0]  n_rd;
  logic [PW-1:0]       pos;
  logic                in_range;
  logic [IDX_W-1:0]    addr_inc;
  logic                rd_last;
  logic                match;
  logic                scan_end;
  logic [PW-1:0]       nx_found;
  logic [CW-1:0]       lvl_c;
  logic [CW-1:0]       span_c;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [BYTE_W-1:0]   mem_rdata;

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready && (cfg_idx == REG_BUFFER_SIZE);
  assign prdata  = (cfg_idx == REG_BUFFER_SIZE) ? APB_DW'(size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (cfg_wr) begin
      size_q <= pwdata[SIZE_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Handshake and shared decode
  // ---------------------------------------------------------------------
  assign act        = action_e'(action_i);
  assign out_free   = !out_valid_q || !out_stall_i;
  // Take new words only in idle and only when the result can be registered.
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Effective size: register saturated to the store depth.
  assign size_ext = CW'(size_q);
  assign eff_c    = (size_ext > DEPTH_C) ? DEPTH_C : size_ext;

  // Write: rewind when empty, then store while below the size.
  assign wi_base = (wi_q == ri_q) ? '0 : wi_q;
  assign ri_base = (wi_q == ri_q) ? '0 : ri_q;
  assign wr_ok   = CW'(wi_base) < eff_c;

  // Read: saturate the request, then clip to the unread bytes.
  assign avail   = wi_q - ri_q;
  assign avail_c = CW'(avail);
  assign req_sat = (read_count_i > MAX_READ_C) ? MAX_READ_C : read_count_i;
  assign n_rd    = (avail_c > CW'(req_sat)) ? req_sat : avail_c[COUNT_W-1:0];

  // Search: first scan position and whether it lies in the written data.
  assign pos      = PW'(ri_q) + PW'(start_offset_i);
  assign in_range = pos < PW'(wi_q);

  assign addr_inc = addr_q + 1'b1;
  assign rd_last  = (k_q + 1'b1) == n_q;
  assign match    = mem_rdata == byte_q;
  assign scan_end = PW'(addr_inc) >= PW'(wi_q);
  assign nx_found = PW'(addr_q) - PW'(ri_q) + 1'b1;
  assign span_c   = CW'(wi_q) - CW'(ri_q);

  // ---------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (act == ACT_READ) && !discard_i && (n_rd != '0)) begin
          state_d = ST_READ;
        end else if (in_acc && (act == ACT_SEARCH) && in_range) begin
          state_d = ST_SEARCH;
        end
      end
      ST_READ: begin
        if (out_free && rd_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_SEARCH: begin
        if (out_free && (match || scan_end)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: datapath, store access and result
  // Store writes happen only in idle and reads only for read or search
  // words, so a write never meets a read of the same entry in flight.
  // ---------------------------------------------------------------------
  always_comb begin
    wi_d      = wi_q;
    ri_d      = ri_q;
    addr_d    = addr_q;
    n_d       = n_q;
    k_d       = k_q;
    byte_d    = byte_q;
    mem_we    = 1'b0;
    mem_waddr = wi_base[AW-1:0];
    mem_re    = 1'b0;
    mem_raddr = '0;
    res_load  = 1'b0;
    res_d     = '0;
    lvl_c     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (act)
            ACT_WRITE: begin
              wi_d       = wi_base;
              ri_d       = ri_base;
              res_load   = 1'b1;
              res_d.last = 1'b1;
              if (wr_ok) begin
                mem_we         = 1'b1;
                wi_d           = wi_base + 1'b1;
                res_d.accepted = 1'b1;
              end
            end
            ACT_READ: begin
              ri_d              = ri_q + IDX_W'(n_rd);
              res_d.moved_count = n_rd;
              if (discard_i || (n_rd == '0)) begin
                res_load   = 1'b1;
                res_d.last = 1'b1;
              end else begin
                // Prefetch the first byte; deliver from the read state.
                mem_re    = 1'b1;
                mem_raddr = ri_q[AW-1:0];
                addr_d    = ri_q + 1'b1;
                n_d       = n_rd;
                k_d       = '0;
              end
            end
            ACT_SEARCH: begin
              byte_d = data_byte_i;
              if (in_range) begin
                mem_re    = 1'b1;
                mem_raddr = pos[AW-1:0];
                addr_d    = pos[IDX_W-1:0];
              end else begin
                res_load          = 1'b1;
                res_d.next_offset = start_offset_i;
                res_d.last        = 1'b1;
              end
            end
            ACT_CLEAR: begin
              wi_d       = '0;
              ri_d       = '0;
              res_load   = 1'b1;
              res_d.last = 1'b1;
            end
            default: begin
              res_load = 1'b0;
            end
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          // Deliver the fetched byte and fetch the next one.
          res_load          = 1'b1;
          res_d.out_byte    = mem_rdata;
          res_d.moved_count = n_q;
          res_d.last        = rd_last;
          k_d               = k_q + 1'b1;
          mem_re            = 1'b1;
          mem_raddr         = addr_q[AW-1:0];
          addr_d            = addr_inc;
        end
      end
      ST_SEARCH: begin
        if (out_free) begin
          if (match) begin
            res_load          = 1'b1;
            res_d.found       = 1'b1;
            res_d.next_offset = nx_found[OFFSET_W-1:0];
            res_d.last        = 1'b1;
          end else if (scan_end) begin
            res_load          = 1'b1;
            res_d.next_offset = span_c[OFFSET_W-1:0];
            res_d.last        = 1'b1;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = addr_inc[AW-1:0];
            addr_d    = addr_inc;
          end
        end
      end
      default: begin
        res_load = 1'b0;
      end
    endcase

    // Status fields reflect the indices after the action.
    lvl_c          = CW'(wi_d) - CW'(ri_d);
    res_d.level    = lvl_c[LEVEL_W-1:0];
    res_d.is_empty = wi_d == ri_d;
    res_d.is_full  = CW'(wi_d) == eff_c;
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wi_q        <= '0;
      ri_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wi_q    <= wi_d;
      ri_q    <= ri_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    n_q    <= n_d;
    k_q    <= k_d;
    byte_q <= byte_d;
    if (res_load) begin
      res_q <= res_d;
    end
  end

  // ---------------------------------------------------------------------
  // Byte store
  // ---------------------------------------------------------------------
  lbbs_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (data_byte_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // ---------------------------------------------------------------------
  // Outputs
  // ---------------------------------------------------------------------
  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = res_q.out_byte;
  assign accepted_o    = res_q.accepted;
  assign moved_count_o = res_q.moved_count;
  assign found_o       = res_q.found;
  assign next_offset_o = res_q.next_offset;
  assign level_o       = res_q.level;
  assign is_empty_o    = res_q.is_empty;
  assign is_full_o     = res_q.is_full;
  assign last_o        = res_q.last;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `LBBS_ASSERT(a_idx_order, clk_i, rst_ni, ri_q <= wi_q)
  `LBBS_ASSERT(a_wi_bound, clk_i, rst_ni, CW'(wi_q) <= DEPTH_C)
  `LBBS_ASSERT_IMPL(a_accept_idle, clk_i, rst_ni, in_acc, state_q == ST_IDLE)
  `LBBS_ASSERT_IMPL(a_read_count, clk_i, rst_ni, state_q == ST_READ, k_q < n_q)
  `LBBS_ASSERT_IMPL(a_scan_range, clk_i, rst_ni, state_q == ST_SEARCH, addr_q < wi_q)

endmodule

### bench/linear_byte_buffer_with_search_check.sv
// Checker for the linear byte buffer: mirrors the buffer state and compares every result word.
`timescale 1ns / 1ps
module linear_byte_buffer_with_search_check
  import lbbs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  input  logic [APB_DW-1:0]   prdata,
  input  logic                pready,
  input  logic                in_valid_i,
  input  logic                in_stall_o,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [BYTE_W-1:0]   data_byte_i,
  input  logic [COUNT_W-1:0]  read_count_i,
  input  logic                discard_i,
  input  logic [OFFSET_W-1:0] start_offset_i,
  input  logic                out_valid_o,
  input  logic                out_stall_i,
  input  logic [BYTE_W-1:0]   out_byte_o,
  input  logic                accepted_o,
  input  logic [COUNT_W-1:0]  moved_count_o,
  input  logic                found_o,
  input  logic [OFFSET_W-1:0] next_offset_o,
  input  logic [LEVEL_W-1:0]  level_o,
  input  logic                is_empty_o,
  input  logic                is_full_o,
  input  logic                last_o,
  output int                  pending_o,
  output int                  errors_o
);

  logic [BYTE_W-1:0] shadow_bytes [DEPTH_DEF];
  logic [SIZE_W-1:0] wr_at;
  logic [SIZE_W-1:0] rd_at;
  logic [SIZE_W-1:0] size_reg;
  result_t           owed_results [$];
  int                mismatches = 0;

  assign errors_o = mismatches;

  function automatic int unsigned usable_size();
    return (size_reg > DEPTH_DEF) ? DEPTH_DEF : size_reg;
  endfunction

  // Level and flags always reflect the indices after the action.
  function automatic void owe(logic [BYTE_W-1:0] ob, logic acc, logic [COUNT_W-1:0] moved,
                              logic fnd, logic [OFFSET_W-1:0] nxt, logic lst);
    result_t r;
    r.out_byte    = ob;
    r.accepted    = acc;
    r.moved_count = moved;
    r.found       = fnd;
    r.next_offset = nxt;
    r.level       = wr_at - rd_at;
    r.is_empty    = (wr_at == rd_at);
    r.is_full     = (wr_at == usable_size());
    r.last        = lst;
    owed_results.push_back(r);
  endfunction

  function automatic void apply_action(action_e act, logic [BYTE_W-1:0] db,
                                       logic [COUNT_W-1:0] rc, logic disc,
                                       logic [OFFSET_W-1:0] so);
    int unsigned want;
    int unsigned n;
    int unsigned pos;
    int unsigned k;
    logic        hit;
    int unsigned nxt;
    case (act)
      ACT_WRITE: begin
        if (wr_at == rd_at) begin
          wr_at = '0;
          rd_at = '0;
        end
        if (wr_at < usable_size()) begin
          shadow_bytes[wr_at % DEPTH_DEF] = db;
          wr_at = wr_at + 1'b1;
          owe('0, 1'b1, '0, 1'b0, '0, 1'b1);
        end else begin
          owe('0, 1'b0, '0, 1'b0, '0, 1'b1);
        end
      end
      ACT_READ: begin
        want  = (rc > MAX_READ_DEF) ? MAX_READ_DEF : rc;
        n     = ((wr_at - rd_at) > want) ? want : (wr_at - rd_at);
        pos   = rd_at;
        rd_at = rd_at + n;
        if (disc || n == 0) begin
          owe('0, 1'b0, COUNT_W'(n), 1'b0, '0, 1'b1);
        end else begin
          for (k = 0; k < n; k++)
            owe(shadow_bytes[(pos + k) % DEPTH_DEF], 1'b0, COUNT_W'(n), 1'b0, '0, k + 1 == n);
        end
      end
      ACT_SEARCH: begin
        pos = rd_at + so;
        hit = 1'b0;
        while (pos < wr_at && !hit) begin
          if (shadow_bytes[pos % DEPTH_DEF] == db) hit = 1'b1;
          else pos++;
        end
        if (hit) nxt = pos - rd_at + 1;
        else if (rd_at + so < wr_at) nxt = wr_at - rd_at;
        else nxt = so;
        owe('0, 1'b0, '0, hit, OFFSET_W'(nxt), 1'b1);
      end
      default: begin
        wr_at = '0;
        rd_at = '0;
        owe('0, 1'b0, '0, 1'b0, '0, 1'b1);
      end
    endcase
  endfunction

  function automatic void field_check(string what, logic [8:0] want, logic [8:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  function automatic void check_word(result_t want);
    field_check("out_byte", want.out_byte, out_byte_o);
    field_check("accepted", want.accepted, accepted_o);
    field_check("moved_count", want.moved_count, moved_count_o);
    field_check("found", want.found, found_o);
    field_check("next_offset", want.next_offset, next_offset_o);
    field_check("level", want.level, level_o);
    field_check("is_empty", want.is_empty, is_empty_o);
    field_check("is_full", want.is_full, is_full_o);
    field_check("last", want.last, last_o);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_at    = '0;
      rd_at    = '0;
      size_reg = SIZE_RESET;
      owed_results.delete();
      pending_o <= 0;
    end else begin
      if (psel && penable && pready && paddr[APB_AW-1:2] == REG_BUFFER_SIZE) begin
        if (pwrite) size_reg = pwdata[SIZE_W-1:0];
        else field_check("buffer_size readback", size_reg, prdata[SIZE_W-1:0]);
      end
      // Results belong to earlier words, so retire before predicting.
      if (out_valid_o && !out_stall_i) begin
        if (owed_results.size() == 0) begin
          mismatches++;
          $display("%0t: no result expected, got byte %0d level %0d last %0d",
                   $time, out_byte_o, level_o, last_o);
        end else begin
          check_word(owed_results.pop_front());
        end
      end
      if (in_valid_i && !in_stall_o)
        apply_action(action_e'(action_i), data_byte_i, read_count_i, discard_i,
                     start_offset_i);
      pending_o <= owed_results.size();
    end
  end

endmodule

### bench/linear_byte_buffer_with_search_test.sv
// Top of the linear byte buffer bench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module linear_byte_buffer_with_search_test;
  import lbbs_pkg::*;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [APB_AW-1:0]   paddr          = '0;
  logic [APB_DW-1:0]   pwdata         = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [ACTION_W-1:0] action_i       = '0;
  logic [BYTE_W-1:0]   data_byte_i    = '0;
  logic [COUNT_W-1:0]  read_count_i   = '0;
  logic                discard_i      = 1'b0;
  logic [OFFSET_W-1:0] start_offset_i = '0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [BYTE_W-1:0]   out_byte_o;
  logic                accepted_o;
  logic [COUNT_W-1:0]  moved_count_o;
  logic                found_o;
  logic [OFFSET_W-1:0] next_offset_o;
  logic [LEVEL_W-1:0]  level_o;
  logic                is_empty_o;
  logic                is_full_o;
  logic                last_o;

  // Idle odds in percent, changed between phases.
  int send_idle_pct  = 37;
  int recv_stall_pct = 60;
  // Tracks whether in_valid_i is currently held high by the sender.
  bit valid_held     = 1'b0;
  int pending_results;
  int mismatch_total;

  linear_byte_buffer_with_search u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .data_byte_i    (data_byte_i),
    .read_count_i   (read_count_i),
    .discard_i      (discard_i),
    .start_offset_i (start_offset_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .accepted_o     (accepted_o),
    .moved_count_o  (moved_count_o),
    .found_o        (found_o),
    .next_offset_o  (next_offset_o),
    .level_o        (level_o),
    .is_empty_o     (is_empty_o),
    .is_full_o      (is_full_o),
    .last_o         (last_o)
  );

  linear_byte_buffer_with_search_check u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .data_byte_i    (data_byte_i),
    .read_count_i   (read_count_i),
    .discard_i      (discard_i),
    .start_offset_i (start_offset_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .accepted_o     (accepted_o),
    .moved_count_o  (moved_count_o),
    .found_o        (found_o),
    .next_offset_o  (next_offset_o),
    .level_o        (level_o),
    .is_empty_o     (is_empty_o),
    .is_full_o      (is_full_o),
    .last_o         (last_o),
    .pending_o      (pending_results),
    .errors_o       (mismatch_total)
  );

  // 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver side: stall at random, odds set by the current phase.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #15_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // One register access: setup cycle, access cycle, then release the bus before returning
  // so the next setup never lands in the same step as the release.
  task automatic apb_access(input bit is_write, input logic [SIZE_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {REG_BUFFER_SIZE, 2'b00};
    pwdata  <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Present one word and hold it until it is taken. A random gap may come first;
  // valid stays up across back-to-back words so it is never dropped and raised
  // in the same step.
  task automatic send_word(action_e act, logic [BYTE_W-1:0] db, logic [COUNT_W-1:0] rc,
                           logic disc, logic [OFFSET_W-1:0] so);
    int gap;
    gap = 0;
    // Idle each cycle with the phase's odds before presenting the word.
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      if (valid_held) in_valid_i <= 1'b0;
      valid_held = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    action_i       <= act;
    data_byte_i    <= db;
    read_count_i   <= rc;
    discard_i      <= disc;
    start_offset_i <= so;
    in_valid_i     <= 1'b1;
    valid_held = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and hold off until every owed result has come out. Each word yields
  // at least one result, so a drained queue means the block is idle.
  task automatic park_sender();
    if (valid_held) in_valid_i <= 1'b0;
    valid_held = 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Random word: small byte alphabet half the time so searches hit, mostly short
  // reads and near offsets, with a tail out to the field limits.
  task automatic random_word(int write_w);
    action_e             act;
    int                  pick;
    logic [BYTE_W-1:0]   db;
    logic [COUNT_W-1:0]  rc;
    logic [OFFSET_W-1:0] so;
    logic                disc;
    pick = $urandom_range(0, 99);
    if (pick >= 96) act = ACT_CLEAR;
    else if (pick < write_w) act = ACT_WRITE;
    else if (pick < write_w + (96 - write_w) / 2) act = ACT_READ;
    else act = ACT_SEARCH;
    db = $urandom_range(0, 1) ? BYTE_W'($urandom_range(0, 7)) : BYTE_W'($urandom_range(0, 255));
    pick = $urandom_range(0, 9);
    if (pick < 7) rc = COUNT_W'($urandom_range(0, 8));
    else if (pick < 9) rc = COUNT_W'($urandom_range(9, 64));
    else rc = COUNT_W'($urandom_range(65, 127));
    disc = ($urandom_range(0, 99) < 15);
    pick = $urandom_range(0, 19);
    if (pick < 15) so = OFFSET_W'($urandom_range(0, 8));
    else if (pick < 18) so = OFFSET_W'($urandom_range(0, 64));
    else so = OFFSET_W'($urandom_range(0, 511));
    send_word(act, db, rc, disc, so);
    // Now and then let the block run dry mid-stream.
    if ($urandom_range(0, 99) < 2) park_sender();
  endtask

  initial begin
    int               phase;
    int               words;
    int               write_w;
    logic [SIZE_W-1:0] size_val;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset value of the size register reads back before anything is written.
    apb_access(1'b0, '0);

    // Directed part at the reset size: empty cases, field extremes, every action.
    send_word(ACT_READ,   8'h00, 7'd5,   1'b0, 9'd0);    // read from empty
    send_word(ACT_SEARCH, 8'h11, 7'd0,   1'b0, 9'd0);    // search on empty
    send_word(ACT_WRITE,  8'h00, 7'd0,   1'b0, 9'd0);
    send_word(ACT_WRITE,  8'hFF, 7'd0,   1'b0, 9'd0);
    send_word(ACT_WRITE,  8'hA5, 7'd0,   1'b0, 9'd0);
    send_word(ACT_WRITE,  8'h5A, 7'd0,   1'b0, 9'd0);
    send_word(ACT_SEARCH, 8'hFF, 7'd0,   1'b0, 9'd0);    // hit
    send_word(ACT_SEARCH, 8'h77, 7'd0,   1'b0, 9'd0);    // miss over all data
    send_word(ACT_SEARCH, 8'hA5, 7'd0,   1'b0, 9'd1);    // hit past a nonzero start
    send_word(ACT_SEARCH, 8'hA5, 7'd0,   1'b0, 9'd300);  // start beyond written data
    send_word(ACT_SEARCH, 8'h00, 7'd127, 1'b1, 9'd511);  // all-ones offset
    send_word(ACT_READ,   8'h00, 7'd1,   1'b1, 9'd0);    // discard one
    send_word(ACT_READ,   8'h00, 7'd127, 1'b0, 9'd0);    // long request, saturates
    send_word(ACT_READ,   8'h00, 7'd0,   1'b0, 9'd0);    // zero count on empty
    send_word(ACT_WRITE,  8'h3C, 7'd0,   1'b0, 9'd0);    // indices met: rewind
    send_word(ACT_WRITE,  8'hC3, 7'd0,   1'b0, 9'd0);
    send_word(ACT_CLEAR,  8'h00, 7'd0,   1'b0, 9'd0);
    send_word(ACT_READ,   8'h00, 7'd64,  1'b1, 9'd0);    // discard on empty
    send_word(ACT_WRITE,  8'hFF, 7'd0,   1'b0, 9'd0);
    park_sender();

    // Random phases: sizes cover the smallest, zero, saturated and a drop below
    // the write index. Idling: sender-light first, then swapped, then none.
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       begin size_val = 9'd1;   write_w = 50; words = 40; end
        1:       begin size_val = 9'd16;  write_w = 60; words = 50; end
        2:       begin size_val = 9'd0;   write_w = 50; words = 30; end
        3:       begin size_val = 9'd511; write_w = 75; words = 70; end
        4:       begin size_val = 9'd4;   write_w = 50; words = 40; end
        5:       begin size_val = 9'd256; write_w = 60; words = 50; end
        6:       begin size_val = 9'd300; write_w = 55; words = 50; end
        default: begin
          size_val = SIZE_W'($urandom_range(1, 256));
          write_w  = 55;
          words    = 50;
        end
      endcase
      if (phase < 3) begin
        send_idle_pct  = 37;
        recv_stall_pct = 60;
      end else if (phase < 6) begin
        send_idle_pct  = 60;
        recv_stall_pct = 37;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      // Block is drained here, so the register may change.
      apb_access(1'b1, size_val);
      apb_access(1'b0, '0);
      repeat (words) random_word(write_w);
      park_sender();
    end

    repeat (20) @(posedge clk_i);
    if (mismatch_total == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
